>>> src/word_frequency_table_unit_macros.svh
// Assertion helpers for the word frequency table unit.
// Each macro samples on the rising edge of clock and is switched off while
// reset is high; the using module must have signals of those names.
`ifndef WORD_FREQUENCY_TABLE_UNIT_MACROS_SVH
`define WORD_FREQUENCY_TABLE_UNIT_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define WFT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("word frequency table: assertion failed");

// Check the consequent in the cycle after the antecedent.
`define WFT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("word frequency table: assertion failed");

`endif

>>> src/wft_pkg.sv
`timescale 1ns / 1ps

package wft_pkg;

   // Fixed field widths of the word and result ports
   localparam int CHAR_W      = 8;
   localparam int COUNT_W     = 16;
   localparam int TOTAL_W     = 32;
   localparam int INDEX_OUT_W = 8;
   localparam int DISTINCT_W  = 9;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef enum logic [2:0] {
      STATUS_NEW      = 3'd0,
      STATUS_COUNTED  = 3'd1,
      STATUS_QFOUND   = 3'd2,
      STATUS_QMISSING = 3'd3,
      STATUS_FULL     = 3'd4,
      STATUS_LONG     = 3'd5
   } wft_status_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } wft_state_type;

   typedef enum logic {
      OP_COUNT = 1'b0,
      OP_QUERY = 1'b1
   } wft_op_type;

endpackage

>>> src/wft_ram.sv
`timescale 1ns / 1ps

module wft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register the read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/word_frequency_table_unit.sv
`timescale 1ns / 1ps

// Word frequency table. Words arrive one character per accepted request on the
// request ports (start high while busy is low), the last character flagged by
// req_last_char. Characters are taken back to back while busy is low. At the
// end of a word the unit walks its entry memory linearly from entry 0, one
// entry per cycle through the registered read port, until a match or the end
// of the stored words; busy stays high until the walk ends. A word that is
// too long is answered without a search. The result appears on the rsp_
// ports for one cycle, marked by rsp_valid, in the cycle after the search
// ends; it cannot be stalled, and the unit is ready for the next word while
// it is shown.
// No clearing pass follows reset: only entries already written are searched.
module word_frequency_table_unit
   import wft_pkg::*;
#(
   parameter int ENTRIES    = 256,
   parameter int WORD_CHARS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_operation,
   input  logic [CHAR_W-1:0]      req_char_byte,
   input  logic                   req_last_char,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_status,
   output logic [INDEX_OUT_W-1:0] rsp_entry_index,
   output logic [COUNT_W-1:0]     rsp_occurrence_count,
   output logic [TOTAL_W-1:0]     rsp_total_words,
   output logic [DISTINCT_W-1:0]  rsp_distinct_words
);

`include "word_frequency_table_unit_macros.svh"

   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int LEN_W = $clog2(WORD_CHARS + 1);
   localparam int ROW_W = WORD_CHARS * CHAR_W + LEN_W;

   // Control state
   wft_state_type    state_ff, state_in;
   logic [CNT_W-1:0] entry_count_ff, entry_count_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic             overlong_ff, overlong_in;
   logic [CNT_W-1:0] issue_ptr_ff, issue_ptr_in;
   logic             cmp_valid_ff, cmp_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload
   logic [CHAR_W-1:0]  word_buf_ff [WORD_CHARS];
   logic [CHAR_W-1:0]  word_buf_in [WORD_CHARS];
   wft_op_type         op_ff, op_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   wft_status_type     rsp_status_ff, rsp_status_in;
   logic [INDEX_OUT_W-1:0] rsp_index_ff, rsp_index_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic [DISTINCT_W-1:0] rsp_distinct_ff, rsp_distinct_in;

   // Memory ports
   logic               row_we;
   logic [ROW_W-1:0]   row_wdata;
   logic [ROW_W-1:0]   row_rdata;
   logic               cnt_we;
   logic [IDX_W-1:0]   cnt_waddr;
   logic [COUNT_W-1:0] cnt_wdata;
   logic [COUNT_W-1:0] cnt_rdata;
   logic [IDX_W-1:0]   rd_addr;

   logic               row_match;
   logic               hit;
   logic               issue;
   logic [COUNT_W-1:0] cnt_inc;
   logic [TOTAL_W-1:0] total_inc;

   // Entry memory: packed characters with the word length on top
   wft_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ENTRIES)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (entry_count_ff[IDX_W-1:0]),
      .wr_data (row_wdata),
      .rd_addr (rd_addr),
      .rd_data (row_rdata)
   );

   // Occurrence count memory, read alongside the entry memory
   wft_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (ENTRIES)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (rd_addr),
      .rd_data (cnt_rdata)
   );

   assign rd_addr = issue_ptr_ff[IDX_W-1:0];

   // Pack the incoming word for an insert
   always_comb begin
      row_wdata = '0;
      for (int i = 0; i < WORD_CHARS; i++) begin
         row_wdata[i*CHAR_W +: CHAR_W] = word_buf_ff[i];
      end
      row_wdata[ROW_W-1 -: LEN_W] = length_ff;
   end

   // Compare the returned entry with the incoming word, characters past its length ignored
   always_comb begin
      row_match = (row_rdata[ROW_W-1 -: LEN_W] == length_ff);
      for (int i = 0; i < WORD_CHARS; i++) begin
         if ((LEN_W'(i) < length_ff) &&
             (row_rdata[i*CHAR_W +: CHAR_W] != word_buf_ff[i])) begin
            row_match = 1'b0;
         end
      end
   end

   assign hit       = cmp_valid_ff && row_match;
   assign cnt_inc   = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + 1'b1;
   assign total_inc = (total_ff == TOTAL_MAX) ? total_ff : total_ff + 1'b1;

   // Next state, search sequencing and result
   always_comb begin
      state_in        = state_ff;
      entry_count_in  = entry_count_ff;
      total_in        = total_ff;
      length_in       = length_ff;
      overlong_in     = overlong_ff;
      issue_ptr_in    = issue_ptr_ff;
      cmp_valid_in    = 1'b0;
      cmp_idx_in      = cmp_idx_ff;
      op_in           = op_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_total_in    = rsp_total_ff;
      rsp_distinct_in = rsp_distinct_ff;
      row_we          = 1'b0;
      cnt_we          = 1'b0;
      cnt_waddr       = cmp_idx_ff;
      cnt_wdata       = cnt_inc;
      issue           = 1'b0;
      for (int i = 0; i < WORD_CHARS; i++) begin
         word_buf_in[i] = word_buf_ff[i];
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // Store the character, or mark the word as too long
               if (length_ff < LEN_W'(WORD_CHARS)) begin
                  for (int i = 0; i < WORD_CHARS; i++) begin
                     if (length_ff == LEN_W'(i)) begin
                        word_buf_in[i] = req_char_byte;
                     end
                  end
                  length_in = length_ff + 1'b1;
               end else begin
                  overlong_in = 1'b1;
               end
               if (req_last_char) begin
                  op_in = wft_op_type'(req_operation);
                  if (overlong_ff || (length_ff == LEN_W'(WORD_CHARS))) begin
                     // Answer an overlong word at once
                     rsp_valid_in    = 1'b1;
                     rsp_status_in   = STATUS_LONG;
                     rsp_index_in    = '0;
                     rsp_count_in    = '0;
                     rsp_total_in    = total_ff;
                     rsp_distinct_in = DISTINCT_W'(entry_count_ff);
                     length_in       = '0;
                     overlong_in     = 1'b0;
                  end else begin
                     state_in     = ST_SEARCH;
                     issue_ptr_in = '0;
                  end
               end
            end
         end

         ST_SEARCH: begin
            // Issue one read per cycle until a match or the end of the table
            issue        = !hit && (issue_ptr_ff < entry_count_ff);
            cmp_valid_in = issue;
            cmp_idx_in   = issue_ptr_ff[IDX_W-1:0];
            if (issue) begin
               issue_ptr_in = issue_ptr_ff + 1'b1;
            end

            if (hit || (issue_ptr_ff == entry_count_ff)) begin
               state_in     = ST_IDLE;
               length_in    = '0;
               overlong_in  = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_index_in = '0;
               rsp_count_in = '0;
               if (hit) begin
                  rsp_index_in = INDEX_OUT_W'(cmp_idx_ff);
                  if (op_ff == OP_COUNT) begin
                     cnt_we        = 1'b1;
                     total_in      = total_inc;
                     rsp_status_in = STATUS_COUNTED;
                     rsp_count_in  = cnt_inc;
                  end else begin
                     rsp_status_in = STATUS_QFOUND;
                     rsp_count_in  = cnt_rdata;
                  end
               end else if (op_ff == OP_QUERY) begin
                  rsp_status_in = STATUS_QMISSING;
               end else if (entry_count_ff >= CNT_W'(ENTRIES)) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  // Append the word with a count of one
                  row_we         = 1'b1;
                  cnt_we         = 1'b1;
                  cnt_waddr      = entry_count_ff[IDX_W-1:0];
                  cnt_wdata      = COUNT_W'(1);
                  entry_count_in = entry_count_ff + 1'b1;
                  total_in       = total_inc;
                  rsp_status_in  = STATUS_NEW;
                  rsp_index_in   = INDEX_OUT_W'(entry_count_ff);
                  rsp_count_in   = COUNT_W'(1);
               end
               rsp_total_in    = total_in;
               rsp_distinct_in = DISTINCT_W'(entry_count_in);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         total_ff       <= '0;
         length_ff      <= '0;
         overlong_ff    <= 1'b0;
         issue_ptr_ff   <= '0;
         cmp_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         total_ff       <= total_in;
         length_ff      <= length_in;
         overlong_ff    <= overlong_in;
         issue_ptr_ff   <= issue_ptr_in;
         cmp_valid_ff   <= cmp_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < WORD_CHARS; i++) begin
         word_buf_ff[i] <= word_buf_in[i];
      end
      op_ff           <= op_in;
      cmp_idx_ff      <= cmp_idx_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_total_ff    <= rsp_total_in;
      rsp_distinct_ff <= rsp_distinct_in;
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_entry_index      = rsp_index_ff;
   assign rsp_occurrence_count = rsp_count_ff;
   assign rsp_total_words      = rsp_total_ff;
   assign rsp_distinct_words   = rsp_distinct_ff;

   // A result always leaves the search behind it
   `WFT_ASSERT_NOW(a_rsp_in_idle, rsp_valid_ff, state_ff == ST_IDLE)
   // A pending compare only exists during a search
   `WFT_ASSERT_NOW(a_cmp_in_search, cmp_valid_ff, state_ff == ST_SEARCH)
   // The table never holds more words than it has entries
   `WFT_ASSERT_NOW(a_count_bound, 1'b1, entry_count_ff <= CNT_W'(ENTRIES))
   // An insert grows the table by exactly one entry
   `WFT_ASSERT_NOW(a_insert_grows,
      rsp_valid_ff && (rsp_status_ff == STATUS_NEW),
      entry_count_ff == $past(entry_count_ff) + 1'b1)

endmodule
